[rtl/las_pkg.sv]
`default_nettype none

package las_pkg;

   // Field and register widths fixed by the interface.
   localparam int CMD_W      = 2;
   localparam int CELL_IDX_W = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   // Command codes carried in the cmd field.
   localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_MODE = 2'd2;

   // Register values after reset.
   localparam logic [CSR_DATA_W-1:0] GRID_ROWS_RST = 7'd64;
   localparam logic [CSR_DATA_W-1:0] GRID_COLS_RST = 7'd64;

   // Input beat.
   typedef struct packed {
      logic [CMD_W-1:0]      cmd;
      logic [CELL_IDX_W-1:0] cell_row;
      logic [CELL_IDX_W-1:0] cell_col;
      logic                  cell_value;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic cell_state;
      logic op_done;
   } rsp_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADV_LAST,
      ST_ADV_FIRST,
      ST_ADV_PRIME,
      ST_ADV_ROW,
      ST_FETCH,
      ST_USE
   } state_type;

   // Read address selection for the row store.
   typedef enum logic [2:0] {
      RD_ZERO,
      RD_LAST,
      RD_NEXT1,
      RD_NEXT2,
      RD_CELL
   } rd_sel_type;

   // Write selection for the row store.
   typedef enum logic [1:0] {
      WR_NONE,
      WR_CLEAR,
      WR_ROW,
      WR_CELL
   } wr_sel_type;

   // Row window update.
   typedef enum logic [1:0] {
      WIN_HOLD,
      WIN_ABOVE,
      WIN_PRIME,
      WIN_SHIFT
   } win_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        req_load;
      logic        row_clr;
      logic        row_inc;
      rd_sel_type  rd_sel;
      wr_sel_type  wr_sel;
      win_sel_type win_sel;
      logic        rsp_fire;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic             clr_last;
      logic             row_last;
      logic             in_grid;
      logic [CMD_W-1:0] cmd;
   } stat_type;

endpackage

`default_nettype wire

[rtl/las_ram.sv]
`default_nettype none

module las_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/las_ctrl.sv]
`default_nettype none

module las_ctrl
   import las_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [CMD_W-1:0] req_cmd,
   input  wire stat_type         stat,
   output ctl_type               ctl,
   output logic                  busy
);

   state_type state_ff;
   state_type state_in;

   // State register; reset starts the clearing sweep of the row store.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               state_in = (req_cmd == CMD_ADVANCE) ? ST_ADV_LAST : ST_FETCH;
            end
         end
         ST_ADV_LAST:  state_in = ST_ADV_FIRST;
         ST_ADV_FIRST: state_in = ST_ADV_PRIME;
         ST_ADV_PRIME: state_in = ST_ADV_ROW;
         ST_ADV_ROW: begin
            if (stat.row_last) state_in = ST_FETCH;
         end
         ST_FETCH: state_in = ST_USE;
         ST_USE:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      ctl          = '0;
      ctl.rd_sel   = RD_ZERO;
      ctl.wr_sel   = WR_NONE;
      ctl.win_sel  = WIN_HOLD;
      case (state_ff)
         ST_CLEAR: begin
            ctl.wr_sel  = WR_CLEAR;
            ctl.row_inc = 1'b1;
         end
         ST_IDLE: begin
            ctl.req_load = start;
            ctl.row_clr  = 1'b1;
         end
         ST_ADV_LAST: begin
            ctl.rd_sel = RD_LAST;
         end
         ST_ADV_FIRST: begin
            ctl.win_sel = WIN_ABOVE;
            ctl.rd_sel  = RD_ZERO;
         end
         ST_ADV_PRIME: begin
            ctl.win_sel = WIN_PRIME;
            ctl.rd_sel  = RD_NEXT1;
         end
         ST_ADV_ROW: begin
            ctl.wr_sel  = WR_ROW;
            ctl.win_sel = WIN_SHIFT;
            ctl.rd_sel  = RD_NEXT2;
            ctl.row_inc = 1'b1;
         end
         ST_FETCH: begin
            ctl.rd_sel = RD_CELL;
         end
         ST_USE: begin
            ctl.rsp_fire = 1'b1;
            if (stat.cmd == CMD_WRITE && stat.in_grid) ctl.wr_sel = WR_CELL;
         end
         default: begin
            ctl.rsp_fire = 1'b0;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

`ifndef NO_ASSERTIONS
   // A result is issued once per item and the controller then returns to idle.
   a_rsp_then_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.rsp_fire |=> (state_ff == ST_IDLE))
      else $error("controller did not return to idle after a result");

   // An accepted item always keeps the block busy in the following cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make the block busy");

   // The row store is never written while the block waits for an item.
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (ctl.wr_sel == WR_NONE))
      else $error("row store written while idle");
`endif

endmodule

`default_nettype wire

[rtl/las_dpath.sv]
`default_nettype none

module las_dpath
   import las_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire req_type               req_data,
   input  wire ctl_type               ctl,
   output stat_type                   stat,
   output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] ram_rd_addr,
   input  wire logic [MAX_COLS-1:0]   ram_rd_data,
   output logic                       ram_wr_en,
   output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] ram_wr_addr,
   output logic [MAX_COLS-1:0]        ram_wr_data,
   output logic                       rsp_strobe,
   output rsp_type                    rsp_data
);

   localparam int RA_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CA_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RN_W = ($clog2(MAX_ROWS + 1) > CSR_DATA_W) ? $clog2(MAX_ROWS + 1)
                                                              : CSR_DATA_W;
   localparam int CN_W = ($clog2(MAX_COLS + 1) > CSR_DATA_W) ? $clog2(MAX_COLS + 1)
                                                              : CSR_DATA_W;

   logic [CSR_DATA_W-1:0] grid_rows_ff;
   logic [CSR_DATA_W-1:0] grid_cols_ff;
   logic                  wrap_ff;
   req_type               req_ff;
   logic [RA_W-1:0]       row_ff;
   logic [RA_W-1:0]       row_in;
   logic [MAX_COLS-1:0]   above_ff;
   logic [MAX_COLS-1:0]   cur_ff;
   logic [MAX_COLS-1:0]   first_ff;
   logic                  rsp_strobe_ff;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;

   logic [RN_W-1:0]       rows_req;
   logic [RN_W-1:0]       rows_lim;
   logic [CN_W-1:0]       cols_req;
   logic [CN_W-1:0]       cols_lim;
   logic [RN_W-1:0]       row_cnt;
   logic [RN_W-1:0]       row_nxt1;
   logic [RN_W-1:0]       row_nxt2;
   logic                  in_grid;
   logic [CA_W-1:0]       edge_idx;
   logic [MAX_COLS-1:0]   below_row;
   logic [MAX_COLS-1:0]   fresh_row;
   logic [MAX_COLS-1:0]   cell_mask;
   logic [MAX_COLS-1:0]   cell_row_data;
   logic [MAX_COLS-1:0]   rd_shift;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= GRID_ROWS_RST;
         grid_cols_ff <= GRID_COLS_RST;
         wrap_ff      <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GRID_ROWS: grid_rows_ff <= csr_wdata;
            CSR_GRID_COLS: grid_cols_ff <= csr_wdata;
            CSR_WRAP_MODE: wrap_ff      <= csr_wdata[0];
            default:       wrap_ff      <= wrap_ff;
         endcase
      end
   end

   // Grid size in use: zero acts as one, anything above the store acts as its size.
   always_comb begin
      rows_req = RN_W'(grid_rows_ff);
      cols_req = CN_W'(grid_cols_ff);
      if (rows_req == '0) begin
         rows_lim = RN_W'(1);
      end else if (rows_req > RN_W'(MAX_ROWS)) begin
         rows_lim = RN_W'(MAX_ROWS);
      end else begin
         rows_lim = rows_req;
      end
      if (cols_req == '0) begin
         cols_lim = CN_W'(1);
      end else if (cols_req > CN_W'(MAX_COLS)) begin
         cols_lim = CN_W'(MAX_COLS);
      end else begin
         cols_lim = cols_req;
      end
   end

   // Accepted item.
   always_ff @(posedge clock) begin
      if (ctl.req_load) begin
         req_ff <= req_data;
      end
   end

   // Row counter, shared by the clearing sweep and the generation sweep.
   always_comb begin
      row_in = row_ff;
      if (ctl.row_clr) begin
         row_in = '0;
      end else if (ctl.row_inc) begin
         row_in = row_ff + RA_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row_cnt  = RN_W'(row_ff);
   assign row_nxt1 = row_cnt + RN_W'(1);
   assign row_nxt2 = row_cnt + RN_W'(2);
   assign in_grid  = (RN_W'(req_ff.cell_row) < rows_lim) &&
                     (CN_W'(req_ff.cell_col) < cols_lim);

   assign stat.clr_last = (row_ff == RA_W'(MAX_ROWS - 1));
   assign stat.row_last = (row_nxt1 == rows_lim);
   assign stat.in_grid  = in_grid;
   assign stat.cmd      = req_ff.cmd;

   // Read address of the row store.
   always_comb begin
      case (ctl.rd_sel)
         RD_LAST:  ram_rd_addr = RA_W'(rows_lim - RN_W'(1));
         RD_NEXT1: ram_rd_addr = (row_nxt1 < rows_lim) ? RA_W'(row_nxt1) : '0;
         RD_NEXT2: ram_rd_addr = (row_nxt2 < rows_lim) ? RA_W'(row_nxt2) : '0;
         RD_CELL:  ram_rd_addr = in_grid ? RA_W'(req_ff.cell_row) : '0;
         default:  ram_rd_addr = '0;
      endcase
   end

   // Row window: the original row above, the current one and the first row.
   always_ff @(posedge clock) begin
      if (reset) begin
         above_ff <= '0;
         cur_ff   <= '0;
         first_ff <= '0;
      end else begin
         case (ctl.win_sel)
            WIN_ABOVE: above_ff <= wrap_ff ? ram_rd_data : '0;
            WIN_PRIME: begin
               cur_ff   <= ram_rd_data;
               first_ff <= ram_rd_data;
            end
            WIN_SHIFT: begin
               above_ff <= cur_ff;
               cur_ff   <= ram_rd_data;
            end
            default: cur_ff <= cur_ff;
         endcase
      end
   end

   // The row below the current one: the next stored row, or past the last row
   // the first row when wrapping and a dead row otherwise.
   always_comb begin
      if (!stat.row_last) begin
         below_row = ram_rd_data;
      end else if (wrap_ff) begin
         below_row = first_ff;
      end else begin
         below_row = '0;
      end
   end

   assign edge_idx = CA_W'(cols_lim - CN_W'(1));

   // One new cell per column; columns beyond the grid keep their stored value.
   for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
      logic       lft_a, lft_c, lft_b;
      logic       rgt_a, rgt_c, rgt_b;
      logic       col_last;
      logic [3:0] nbr_cnt;
      logic       new_cell;

      assign col_last = (cols_lim == CN_W'(c + 1));

      if (c == 0) begin : g_left_edge
         assign lft_a = wrap_ff & above_ff[edge_idx];
         assign lft_c = wrap_ff & cur_ff[edge_idx];
         assign lft_b = wrap_ff & below_row[edge_idx];
      end else begin : g_left_inner
         assign lft_a = above_ff[c-1];
         assign lft_c = cur_ff[c-1];
         assign lft_b = below_row[c-1];
      end

      if (c + 1 < MAX_COLS) begin : g_right_inner
         assign rgt_a = col_last ? (wrap_ff & above_ff[0])  : above_ff[c+1];
         assign rgt_c = col_last ? (wrap_ff & cur_ff[0])    : cur_ff[c+1];
         assign rgt_b = col_last ? (wrap_ff & below_row[0]) : below_row[c+1];
      end else begin : g_right_edge
         assign rgt_a = wrap_ff & above_ff[0];
         assign rgt_c = wrap_ff & cur_ff[0];
         assign rgt_b = wrap_ff & below_row[0];
      end

      assign nbr_cnt = 4'(lft_a) + 4'(above_ff[c]) + 4'(rgt_a) +
                       4'(lft_c) + 4'(rgt_c) +
                       4'(lft_b) + 4'(below_row[c]) + 4'(rgt_b);

      // Birth on three neighbours, survival on two, death otherwise.
      always_comb begin
         case (nbr_cnt)
            4'd3:    new_cell = 1'b1;
            4'd2:    new_cell = cur_ff[c];
            default: new_cell = 1'b0;
         endcase
      end

      assign fresh_row[c] = (CN_W'(c) < cols_lim) ? new_cell : cur_ff[c];
   end

   // Single cell update on a row read back from the store.
   assign cell_mask     = MAX_COLS'(1) << req_ff.cell_col;
   assign cell_row_data = (ram_rd_data & ~cell_mask) |
                          (req_ff.cell_value ? cell_mask : '0);
   assign rd_shift      = ram_rd_data >> req_ff.cell_col;

   // Write port of the row store.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = row_ff;
      ram_wr_data = '0;
      case (ctl.wr_sel)
         WR_CLEAR: begin
            ram_wr_en = 1'b1;
         end
         WR_ROW: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = fresh_row;
         end
         WR_CELL: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = RA_W'(req_ff.cell_row);
            ram_wr_data = cell_row_data;
         end
         default: ram_wr_en = 1'b0;
      endcase
   end

   // Result of the item.
   always_comb begin
      rsp_in = '0;
      case (req_ff.cmd)
         CMD_WRITE: begin
            rsp_in.cell_state = in_grid & req_ff.cell_value;
            rsp_in.op_done    = in_grid;
         end
         CMD_ADVANCE: begin
            rsp_in.cell_state = in_grid & rd_shift[0];
            rsp_in.op_done    = 1'b1;
         end
         CMD_READ: begin
            rsp_in.cell_state = in_grid & rd_shift[0];
            rsp_in.op_done    = in_grid;
         end
         default: rsp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctl.rsp_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef NO_ASSERTIONS
   // The generation sweep only ever writes rows inside the grid in use.
   a_row_in_grid: assert property (@(posedge clock) disable iff (reset)
      (ctl.wr_sel == WR_ROW) |-> (row_cnt < rows_lim))
      else $error("generation sweep wrote a row outside the grid");

   // A single cell is only written when its address lies inside the grid.
   a_cell_in_grid: assert property (@(posedge clock) disable iff (reset)
      (ctl.wr_sel == WR_CELL) |-> (in_grid && req_ff.cmd == CMD_WRITE))
      else $error("cell written outside the grid or by a non-write item");
`endif

endmodule

`default_nettype wire

[rtl/life_automaton_step.sv]
`default_nettype none

// One step of a B3/S23 life automaton on a grid of one-bit cells held in a row store.
// Items enter on req_data when start is high and busy is low; each item gives one
// result beat on rsp_data, marked by rsp_strobe for a single cycle. The receiver
// cannot stall, so every beat must be taken in the cycle it is shown.
// Commands: write one cell, read one cell, or advance the whole grid by a generation.
// Configuration (grid_rows, grid_cols, wrap_mode) is written through csr_we,
// csr_index and csr_wdata, one register per cycle; the user must do so only while
// the block is idle, as the block does not enforce it. A write or read passes
// through FETCH and USE before its result beat, and the next item may be accepted
// in the same cycle as that beat. An advance loads the row window in ADV_LAST,
// ADV_FIRST and ADV_PRIME, runs one grid row per cycle through the neighbour
// counters in ADV_ROW, and reads the addressed cell in FETCH and USE. The
// generation rate is set by the single read port of the row store, which delivers
// one full row per cycle. After reset the block clears all MAX_ROWS rows, one per
// cycle, holding busy high; registers return to a 64 by 64 grid without wrap.
module life_automaton_step
   import las_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire req_type               req_data,
   output logic                       rsp_strobe,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int RA_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   ctl_type             ctl;
   stat_type            stat;
   logic [RA_W-1:0]     ram_rd_addr;
   logic [MAX_COLS-1:0] ram_rd_data;
   logic                ram_wr_en;
   logic [RA_W-1:0]     ram_wr_addr;
   logic [MAX_COLS-1:0] ram_wr_data;

   // Sequencer.
   las_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_data.cmd),
      .stat    (stat),
      .ctl     (ctl),
      .busy    (busy)
   );

   // Registers, row window, neighbour counters and result.
   las_dpath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_data    (req_data),
      .ctl         (ctl),
      .stat        (stat),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data)
   );

   // Cell store, one grid row per word.
   las_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (MAX_ROWS)
   ) u_rows (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire
